// ===== rtl/longest_increasing_subsequence_length_core_macros.svh =====
// Assertion helpers shared by the RTL of the subsequence length core.
`ifndef LONGEST_INCREASING_SUBSEQUENCE_LENGTH_CORE_MACROS_SVH
`define LONGEST_INCREASING_SUBSEQUENCE_LENGTH_CORE_MACROS_SVH

// Same-cycle implication, checked outside of reset.
`define LISL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside of reset.
`define LISL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/lisl_pkg.sv =====
`default_nettype none
package lisl_pkg;

  localparam int VALUE_W     = 31;
  localparam int LEN_W       = 11;
  localparam int MAX_LEN_DEF = 1024;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               last;
  } item_t;

  typedef struct packed {
    logic [LEN_W-1:0] end_length;
    logic [LEN_W-1:0] best_length;
    logic             last_res;
  } res_t;

endpackage
`default_nettype wire

// ===== rtl/longest_increasing_subsequence_length_core.sv =====
// Flow: a word is accepted, then the tail memory gets one lower-bound probe per search step
// (up to ceil(log2(tail_count + 1)) probes, none on an empty table), then a write-back.
// A new word is taken only once the last one is written back, and the write-back waits while
// the result is held by res_stall; the single read port of the tail memory paces the search.
// Reset clears the tail count, the running best and the result valid; the tail memory
// itself is not cleared, since only entries written in the current sequence are read.
`default_nettype none
`include "longest_increasing_subsequence_length_core_macros.svh"
module longest_increasing_subsequence_length_core import lisl_pkg::*; #(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  item_valid,
  output logic       item_stall,
  input  wire item_t item,
  output logic       res_valid,
  input  wire logic  res_stall,
  output res_t       res
);

  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int AW = $clog2(MAX_LEN);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_WRITE
  } state_t;

  state_t             state;
  logic [VALUE_W-1:0] val;
  logic               last_flag;
  logic [CW-1:0]      lo;
  logic [CW-1:0]      hi;
  logic [CW-1:0]      mid;
  logic [CW-1:0]      tail_count;
  logic [CW-1:0]      best_so_far;

  logic [VALUE_W-1:0] rd_data;
  logic [AW-1:0]      rd_addr;
  logic               wr_en;
  logic               less;
  logic [CW-1:0]      lo_next;
  logic [CW-1:0]      hi_next;
  logic [CW-1:0]      mid_next;
  logic               slot_free;
  logic               pos_hit;
  logic               can_add;
  logic [CW-1:0]      end_len;
  logic [CW-1:0]      count_next;
  logic [CW-1:0]      best_next;

  // One probe per cycle: the compare of the word just read picks the next midpoint,
  // whose read is issued in the same cycle.
  always_comb begin
    less     = rd_data < val;
    lo_next  = less ? (mid + CW'(1)) : lo;
    hi_next  = less ? hi : mid;
    mid_next = lo_next + ((hi_next - lo_next) >> 1);
    if (state == ST_IDLE) begin
      rd_addr = AW'(tail_count >> 1);
    end else begin
      rd_addr = AW'(mid_next);
    end
  end

  always_comb begin
    slot_free = !res_valid || !res_stall;
    pos_hit   = lo < tail_count;
    can_add   = tail_count < CW'(MAX_LEN);
    priority if (pos_hit) begin
      end_len    = lo + CW'(1);
      count_next = tail_count;
    end else if (can_add) begin
      end_len    = tail_count + CW'(1);
      count_next = tail_count + CW'(1);
    end else begin
      end_len    = CW'(MAX_LEN);
      count_next = tail_count;
    end
    best_next = (end_len > best_so_far) ? end_len : best_so_far;
    wr_en     = (state == ST_WRITE) && slot_free && (pos_hit || can_add);
  end

  assign item_stall = state != ST_IDLE;

  lisl_tail_ram #(
    .DEPTH (MAX_LEN),
    .AW    (AW)
  ) u_tails (
    .clk   (clk),
    .we    (wr_en),
    .waddr (AW'(lo)),
    .wdata (val),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      res_valid   <= 1'b0;
      tail_count  <= '0;
      best_so_far <= '0;
    end else begin
      if ((state == ST_WRITE) && slot_free) begin
        res_valid <= 1'b1;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (item_valid) begin
            val       <= item.value;
            last_flag <= item.last;
            lo        <= '0;
            hi        <= tail_count;
            mid       <= tail_count >> 1;
            state     <= (tail_count == '0) ? ST_WRITE : ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          lo  <= lo_next;
          hi  <= hi_next;
          mid <= mid_next;
          if (lo_next == hi_next) begin
            state <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          if (slot_free) begin
            res.end_length  <= LEN_W'(end_len);
            res.best_length <= LEN_W'(best_next);
            res.last_res    <= last_flag;
            state           <= ST_IDLE;
            if (last_flag) begin
              tail_count  <= '0;
              best_so_far <= '0;
            end else begin
              tail_count  <= count_next;
              best_so_far <= best_next;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `LISL_ASSERT_NOW(a_mid_in_range, clk, rst, state == ST_SEARCH, (mid >= lo) && (mid < hi), "search midpoint left its interval")
  `LISL_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, tail_count <= CW'(MAX_LEN), "tail count exceeds table depth")
  `LISL_ASSERT_NOW(a_best_covers_count, clk, rst, 1'b1, tail_count <= best_so_far, "running best below tail count")
  `LISL_ASSERT_NEXT(a_write_delivers, clk, rst, (state == ST_WRITE) && slot_free, res_valid && (state == ST_IDLE), "write-back did not present a result")

endmodule
`default_nettype wire

// ===== rtl/lisl_tail_ram.sv =====
`default_nettype none
module lisl_tail_ram import lisl_pkg::*; #(
  parameter int DEPTH = MAX_LEN_DEF,
  parameter int AW    = $clog2(MAX_LEN_DEF)
) (
  input  wire logic               clk,
  input  wire logic               we,
  input  wire logic [AW-1:0]      waddr,
  input  wire logic [VALUE_W-1:0] wdata,
  input  wire logic [AW-1:0]      raddr,
  output logic      [VALUE_W-1:0] rdata
);

  logic [VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire
